// ----- src/nue_pkg.sv -----
package nue_pkg;

	// Widths of the packed stream words.
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 40;

	// Largest output size honored; larger capacity values are clamped to it.
	localparam int MAX_OUTPUT_BYTES = 1023;

	// Configuration register indexes.
	localparam logic CFG_EIGHT_BIT_MODE  = 1'b0;
	localparam logic CFG_OUTPUT_CAPACITY = 1'b1;

	// Character codes handled specially.
	localparam logic [15:0] CH_NULL       = 16'h0000;
	localparam logic [15:0] CH_SLASH      = 16'h002F;
	localparam logic [15:0] CH_PERIOD     = 16'h002E;
	localparam logic [7:0]  CH_UNDERSCORE = 8'h5F;

	// One accepted input item.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        first_unit;
		logic        last_unit;
		logic [7:0]  name_bytes;
	} nue_item_t;

	// Per-name running state.
	typedef struct packed {
		logic [9:0] space_left;
		logic [1:0] invalid_run;
		logic [7:0] unit_count;
		logic [7:0] period_offset;
		logic       truncated_flag;
	} nue_state_t;

	// Everything the emitter needs to play out the results of one item.
	typedef struct packed {
		logic [23:0] bytes;       // byte 0 in the lowest bits
		logic [1:0]  nbytes;
		logic [1:0]  last_idx;    // index of the final result of this item
		logic [9:0]  unit_start;
		logic [9:0]  out_length;
		logic        needs_crc;
		logic [7:0]  ext_location;
		logic        last_unit;
	} nue_bundle_t;

	// Bytes written so far, floored at zero when the capacity shrank mid-name.
	function automatic logic [9:0] nue_written(input logic [9:0] cap, input logic [9:0] left);
		return (cap >= left) ? (cap - left) : 10'd0;
	endfunction

endpackage

// ----- src/nue_encode.sv -----
module nue_encode
	import nue_pkg::*;
(
	input  nue_item_t   item,
	input  nue_state_t  cur,
	input  logic        eight_bit_mode,
	input  logic [9:0]  cap,
	output nue_state_t  nxt,
	output nue_bundle_t bundle
);

	// Conversion of one code unit and the state update that follows it.
	always_comb begin
		nue_state_t  st;
		logic [15:0] ch;
		logic [1:0]  need;
		logic [23:0] enc;
		logic [9:0]  pos;
		logic [9:0]  nb;
		logic [9:0]  endi;
		logic [9:0]  start;
		logic [1:0]  nbytes;
		logic        hit;

		// A new name clears the per-name state first.
		if (item.first_unit) begin
			st.space_left     = cap;
			st.invalid_run    = 2'd0;
			st.unit_count     = 8'd0;
			st.period_offset  = 8'd0;
			st.truncated_flag = 1'b0;
		end else begin
			st = cur;
		end

		ch    = eight_bit_mode ? {8'h00, item.code_unit[7:0]} : item.code_unit;
		pos   = eight_bit_mode ? {2'b00, st.unit_count} : {1'b0, st.unit_count, 1'b0};
		nb    = {2'b00, item.name_bytes};
		endi  = eight_bit_mode ? nb : ((nb != 10'd0) ? (nb - 10'd1) : 10'd0);
		start = nue_written(cap, st.space_left);

		// UTF-8 encoding of a unit of at most 16 bits.
		if (ch[15:7] == 9'd0) begin
			need = 2'd1;
			enc  = {16'h0000, 1'b0, ch[6:0]};
		end else if (ch[15:11] == 5'd0) begin
			need = 2'd2;
			enc  = {8'h00, 2'b10, ch[5:0], 3'b110, ch[10:6]};
		end else begin
			need = 2'd3;
			enc  = {2'b10, ch[5:0], 2'b10, ch[11:6], 4'b1110, ch[15:12]};
		end

		nbytes = 2'd0;
		bundle.bytes = 24'd0;

		if (st.space_left == 10'd0) begin
			st.truncated_flag = 1'b1;
		end else if (ch == CH_NULL || ch == CH_SLASH) begin
			if (st.invalid_run != 2'd3) st.invalid_run = st.invalid_run + 2'd1;
		end else if ({8'd0, need} > st.space_left) begin
			if (st.invalid_run != 2'd3) st.invalid_run = st.invalid_run + 2'd1;
			st.truncated_flag = 1'b1;
		end else begin
			nbytes = need;
			bundle.bytes = enc;
			st.space_left = st.space_left - {8'd0, need};
			st.invalid_run = 2'd0;
		end

		// Period near the end of the name becomes the extension position.
		if (eight_bit_mode) begin
			hit = (nb < pos + 10'd6) && (pos + 10'd1 != endi);
		end else begin
			hit = (nb < pos + 10'd12) && (pos + 10'd2 != endi);
		end
		if (ch == CH_PERIOD && pos != 10'd1 && pos[9:8] == 2'b00 && hit) begin
			st.period_offset = pos[7:0];
		end

		// The first invalid unit of a run is replaced by one underscore.
		if (st.space_left != 10'd0 && st.invalid_run == 2'd1) begin
			bundle.bytes = {16'h0000, CH_UNDERSCORE};
			nbytes = 2'd1;
			st.space_left = st.space_left - 10'd1;
			st.invalid_run = 2'd2;
		end

		if (st.unit_count != 8'hFF) st.unit_count = st.unit_count + 8'd1;

		nxt = st;

		bundle.nbytes       = nbytes;
		bundle.unit_start   = start;
		bundle.out_length   = nue_written(cap, st.space_left);
		bundle.needs_crc    = st.truncated_flag;
		bundle.ext_location = st.period_offset;
		bundle.last_unit    = item.last_unit;
		// Bytes, then the summary on the last unit; a unit with neither gets one filler.
		if (nbytes == 2'd0) begin
			bundle.last_idx = 2'd0;
		end else begin
			bundle.last_idx = nbytes - 2'd1 + {1'b0, item.last_unit};
		end
	end

endmodule

// ----- src/cs0_name_to_utf8_encoder.sv -----
// Pipeline: an accepted item goes through the input register into the result register.
// Throughput: one result per cycle while m_tready is high; an item gives 1 to 4 results
// (its UTF-8 bytes, the summary on the last unit, or a filler when it has neither),
// played out by the single result register, refilled as its final result leaves.
// Reset: arst_n clears all control state at once; eight_bit_mode resets to 1,
// output_capacity to 255, and the name state to an empty name of 255 bytes.
module cs0_name_to_utf8_encoder
	import nue_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // code_unit[15:0], name_bytes[23:16]
	input  logic                 s_tuser,   // first_unit
	input  logic                 s_tlast,   // last_unit
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // out_byte[7:0], unit_start[17:8],
	                                        // ext_location[25:18], out_length[35:26], zero
	output logic [2:0]           m_tuser,   // byte_valid[0], needs_crc[1], name_done[2]
	output logic                 m_tlast,   // last_of_run
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [9:0]           cfg_data
);

	logic        eight_bit_mode_q;
	logic [9:0]  output_capacity_q;
	logic [9:0]  cap;
	nue_state_t  state_q;
	nue_state_t  state_nxt;
	nue_item_t   item_s1;
	logic        valid_s1;
	nue_bundle_t bundle;
	nue_bundle_t res_q;
	logic        res_valid_q;
	logic [1:0]  idx_q;
	logic        res_final;
	logic        load;
	logic        is_byte;
	logic        is_summary;
	logic [7:0]  byte_sel;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eight_bit_mode_q  <= 1'b1;
			output_capacity_q <= 10'd255;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_EIGHT_BIT_MODE:  eight_bit_mode_q  <= cfg_data[0];
				CFG_OUTPUT_CAPACITY: output_capacity_q <= cfg_data;
			endcase
		end
	end

	assign cap = (32'(output_capacity_q) > MAX_OUTPUT_BYTES) ?
	             10'(MAX_OUTPUT_BYTES) : output_capacity_q;

	// Input register.
	assign res_final = (idx_q == res_q.last_idx);
	assign load      = valid_s1 && (!res_valid_q || (m_tready && res_final));
	assign s_tready  = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.code_unit  <= s_tdata[15:0];
			item_s1.name_bytes <= s_tdata[23:16];
			item_s1.first_unit <= s_tuser;
			item_s1.last_unit  <= s_tlast;
		end
	end

	nue_encode u_encode (
		.item           (item_s1),
		.cur            (state_q),
		.eight_bit_mode (eight_bit_mode_q),
		.cap            (cap),
		.nxt            (state_nxt),
		.bundle         (bundle)
	);

	// Name state advances when an item moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.space_left     <= 10'd255;
			state_q.invalid_run    <= 2'd0;
			state_q.unit_count     <= 8'd0;
			state_q.period_offset  <= 8'd0;
			state_q.truncated_flag <= 1'b0;
		end else if (load) begin
			state_q <= state_nxt;
		end
	end

	// Result register: one result of the held item per cycle while m_tready is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			res_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (res_valid_q && m_tready) begin
			if (res_final) begin
				res_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bundle;
		end
	end

	// Output fields of the current result.
	always_comb begin
		case (idx_q)
			2'd0:    byte_sel = res_q.bytes[7:0];
			2'd1:    byte_sel = res_q.bytes[15:8];
			2'd2:    byte_sel = res_q.bytes[23:16];
			default: byte_sel = 8'h00;
		endcase
	end

	assign is_byte    = ({1'b0, idx_q} < {1'b0, res_q.nbytes});
	assign is_summary = !is_byte && res_q.last_unit;

	assign m_tvalid = res_valid_q;
	assign m_tlast  = res_final;
	assign m_tuser  = {is_summary, res_q.needs_crc, is_byte};
	assign m_tdata  = {4'd0, res_q.out_length, res_q.ext_location,
	                   (is_summary ? res_q.out_length : res_q.unit_start),
	                   (is_byte ? byte_sel : 8'h00)};

	// A summary result always closes the run of its item.
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tlast)
		else $error("summary result not marked last of run");

	// A result never carries a byte and the summary at once.
	a_byte_or_summary: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
		else $error("result marked both byte and summary");

	// The result index never passes the final result of the held item.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (idx_q <= res_q.last_idx))
		else $error("result index beyond final result");

	// An accepted item is held in the input register next cycle.
	a_accept_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item lost from input register");

endmodule

// ----- tb/sv/tb_cs0_name_to_utf8_encoder.sv -----
`timescale 1ns / 100ps

module tb_cs0_name_to_utf8_encoder;
	import nue_pkg::*;

	// One expected output item, one field per result column.
	typedef struct {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [9:0] unit_start;
		logic       needs_crc;
		logic [7:0] ext_location;
		logic [9:0] out_length;
		logic       name_done;
		logic       last_of_run;
	} utf8_result_t;

	logic                 clk = 1'b1;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [2:0]           m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_index = CFG_EIGHT_BIT_MODE;
	logic [9:0]           cfg_data = '0;

	// Code units waiting to be sent, and UTF-8 items waiting to come out.
	nue_item_t    unit_queue[$];
	utf8_result_t utf8_expected[$];

	// Shadow copy of the configuration and of the per-name state.
	bit         mode_8bit = 1'b1;
	logic [9:0] name_cap = 10'd255;
	logic [9:0] bytes_free = 10'd255;
	logic [1:0] bad_run = '0;
	logic [7:0] units_seen = '0;
	logic [7:0] dot_offset = '0;
	logic       overflowed = 1'b0;

	// Traffic shaping.
	bit src_idle = 1'b1;
	bit sink_idle = 1'b1;
	int src_gap = 0;
	int sink_stall = 0;
	logic s_fire = 1'b0;
	int mismatches = 0;

	cs0_name_to_utf8_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Bytes written so far in the current name; zero if the capacity shrank below use.
	function automatic logic [9:0] bytes_out();
		return (name_cap >= bytes_free) ? name_cap - bytes_free : 10'd0;
	endfunction

	// Encode one accepted code unit and queue the output items it produces.
	function automatic void encode_unit(input nue_item_t it);
		logic [15:0] ch;
		logic [7:0]  enc[4];
		logic [9:0]  start;
		int          nbytes;
		logic [9:0]  need;
		int          pos;
		int          endi;
		int          nb;
		int          nres;
		bit          qualifies;
		utf8_result_t r;

		if (it.first_unit) begin
			bytes_free = name_cap;
			bad_run = '0;
			units_seen = '0;
			dot_offset = '0;
			overflowed = 1'b0;
		end
		ch = it.code_unit;
		if (mode_8bit)
			ch[15:8] = 8'h00;
		nb = it.name_bytes;
		pos = mode_8bit ? units_seen : 2 * units_seen;
		endi = mode_8bit ? nb : ((nb > 1) ? nb - 1 : 0);
		start = bytes_out();
		nbytes = 0;

		if (bytes_free == 0) begin
			overflowed = 1'b1;
		end else if (ch == CH_NULL || ch == CH_SLASH) begin
			if (bad_run < 3)
				bad_run++;
		end else begin
			// One, two or three byte UTF-8 sequence.
			if (ch < 16'h0080) begin
				need = 10'd1;
				enc[0] = ch[7:0];
			end else if (ch < 16'h0800) begin
				need = 10'd2;
				enc[0] = 8'hC0 | ch[10:6];
				enc[1] = 8'h80 | ch[5:0];
			end else begin
				need = 10'd3;
				enc[0] = 8'hE0 | ch[15:12];
				enc[1] = 8'h80 | ch[11:6];
				enc[2] = 8'h80 | ch[5:0];
			end
			if (need > bytes_free) begin
				if (bad_run < 3)
					bad_run++;
				overflowed = 1'b1;
			end else begin
				nbytes = need;
				bytes_free -= need;
				bad_run = '0;
			end
		end

		// A period close enough to the end of the stored name marks the extension.
		if (ch == CH_PERIOD && pos != 1 && pos <= 255) begin
			if (mode_8bit)
				qualifies = (nb - 6 < pos) && (pos + 1 != endi);
			else
				qualifies = (nb - 12 < pos) && (pos + 2 != endi);
			if (qualifies)
				dot_offset = pos[7:0];
		end

		// The first bad unit of a run turns into a single underscore.
		if (bytes_free > 0 && bad_run == 1) begin
			enc[nbytes] = CH_UNDERSCORE;
			nbytes++;
			bytes_free--;
			bad_run = 2'd2;
		end
		if (units_seen < 255)
			units_seen++;

		nres = nbytes + ((nbytes == 0 && !it.last_unit) ? 1 : 0) + (it.last_unit ? 1 : 0);
		for (int k = 0; k < nres; k++) begin
			r.out_byte = (k < nbytes) ? enc[k] : 8'h00;
			r.byte_valid = (k < nbytes);
			r.name_done = it.last_unit && (k == nres - 1);
			r.unit_start = r.name_done ? bytes_out() : start;
			r.needs_crc = overflowed;
			r.ext_location = dot_offset;
			r.out_length = bytes_out();
			r.last_of_run = (k == nres - 1);
			utf8_expected.push_back(r);
		end
	endfunction

	// Gap length: mostly none, often short, now and then long.
	function automatic int next_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [15:0] random_unit();
		int r;
		logic [15:0] u;
		r = $urandom_range(0, 99);
		if (r < 8)
			u = CH_NULL;
		else if (r < 16)
			u = CH_SLASH;
		else if (r < 30)
			u = CH_PERIOD;
		else if (r < 60)
			u = 16'($urandom_range(16'h20, 16'h7E));
		else if (r < 80)
			u = 16'($urandom_range(16'h80, mode_8bit ? 16'hFF : 16'h7FF));
		else
			u = 16'($urandom_range(0, 16'hFFFF));
		// The upper byte is ignored in eight-bit mode, so scramble it now and then.
		if (mode_8bit && $urandom_range(0, 3) == 0)
			u[15:8] = 8'($urandom_range(0, 255));
		return u;
	endfunction

	task automatic queue_unit(input logic [15:0] u, input bit f, input bit l,
		input logic [7:0] nb);
		unit_queue.push_back('{code_unit: u, first_unit: f, last_unit: l, name_bytes: nb});
	endtask

	// Mostly well-formed names; some with scrambled first and last marks.
	task automatic queue_names(input int budget);
		int made;
		int len;
		int nb;
		int style;
		bit f;
		bit l;
		made = 0;
		while (made < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			style = $urandom_range(0, 9);
			nb = mode_8bit ? len : 2 * len;
			if (nb > 255)
				nb = 255;
			if (style == 1)
				nb = $urandom_range(0, 255);
			for (int i = 0; i < len; i++) begin
				if (style == 0) begin
					f = ($urandom_range(0, 3) == 0);
					l = ($urandom_range(0, 3) == 0);
				end else begin
					f = (i == 0);
					l = (i == len - 1);
				end
				queue_unit(random_unit(), f, l, nb[7:0]);
			end
			made += len;
		end
	endtask

	// A long name that walks past the extension window and saturates the unit count.
	task automatic queue_long_name(input int len);
		logic [15:0] u;
		for (int i = 0; i < len; i++) begin
			if (i >= 115 && i <= 140 && $urandom_range(0, 2) == 0)
				u = CH_PERIOD;
			else if ($urandom_range(0, 30) == 0)
				u = 16'($urandom_range(16'h0800, 16'hFFFF));
			else
				u = 16'($urandom_range(16'h20, 16'h7E));
			queue_unit(u, i == 0, i == len - 1, 8'd255);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_EIGHT_BIT_MODE)
			mode_8bit = value[0];
		else
			name_cap = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every queued unit went in and every expected item came out.
	task automatic wait_drained();
		while (unit_queue.size() != 0 || s_tvalid || utf8_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input bit mode, input logic [9:0] cap, input bit src_on,
		input bit sink_on, input int budget);
		wait_drained();
		write_reg(CFG_EIGHT_BIT_MODE, {9'd0, mode});
		write_reg(CFG_OUTPUT_CAPACITY, cap);
		src_idle = src_on;
		sink_idle = sink_on;
		queue_names(budget);
	endtask

	// Input driver: presents queued units, holding each until it is taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (unit_queue.size() != 0) begin
				s_tdata <= {unit_queue[0].name_bytes, unit_queue[0].code_unit};
				s_tuser <= unit_queue[0].first_unit;
				s_tlast <= unit_queue[0].last_unit;
				s_tvalid <= 1'b1;
				void'(unit_queue.pop_front());
				src_gap = next_gap(src_idle);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output ready: random stalls of varying length.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			m_tready <= 1'b0;
		end else if (sink_idle && $urandom_range(0, 4) == 0) begin
			sink_stall = next_gap(1'b1);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic compare_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	// Monitor: predicts on every accepted unit and checks every accepted output item.
	always @(posedge clk) begin : result_monitor
		utf8_result_t want;
		s_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			encode_unit(nue_item_t'({s_tdata[15:0], s_tuser, s_tlast, s_tdata[23:16]}));
		if (arst_n && m_tvalid && m_tready) begin
			if (utf8_expected.size() == 0) begin
				$error("unexpected item: tdata 0x%0h tuser 0x%0h", m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = utf8_expected.pop_front();
				compare_field("out_byte", want.out_byte, m_tdata[7:0]);
				compare_field("byte_valid", want.byte_valid, m_tuser[0]);
				compare_field("unit_start", want.unit_start, m_tdata[17:8]);
				compare_field("needs_crc", want.needs_crc, m_tuser[1]);
				compare_field("ext_location", want.ext_location, m_tdata[25:18]);
				compare_field("out_length", want.out_length, m_tdata[35:26]);
				compare_field("name_done", want.name_done, m_tuser[2]);
				compare_field("last_of_run", want.last_of_run, m_tlast);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single unit with an empty stored length.
		queue_unit(16'h0041, 1'b1, 1'b1, 8'd0);
		// Eight-bit name: a bad run that saturates, a period at offset one,
		// an ignored upper byte, and a period in the extension window.
		queue_unit(CH_NULL, 1'b1, 1'b0, 8'd9);
		queue_unit(CH_PERIOD, 1'b0, 1'b0, 8'd9);
		queue_unit(CH_SLASH, 1'b0, 1'b0, 8'd9);
		queue_unit(CH_NULL, 1'b0, 1'b0, 8'd9);
		queue_unit(16'hAB80, 1'b0, 1'b0, 8'd9);
		queue_unit(16'hFFFF, 1'b0, 1'b0, 8'd9);
		queue_unit(16'h007F, 1'b0, 1'b0, 8'd9);
		queue_unit(CH_PERIOD, 1'b0, 1'b0, 8'd9);
		queue_unit(16'h0061, 1'b0, 1'b1, 8'd9);
		wait_drained();

		// Sixteen-bit units into five bytes: units that no longer fit, then a full output.
		write_reg(CFG_EIGHT_BIT_MODE, 10'd0);
		write_reg(CFG_OUTPUT_CAPACITY, 10'd5);
		queue_unit(16'hFFFF, 1'b1, 1'b0, 8'd16);
		queue_unit(16'h0800, 1'b0, 1'b0, 8'd16);
		queue_unit(16'h07FF, 1'b0, 1'b0, 8'd16);
		queue_unit(16'h0041, 1'b0, 1'b0, 8'd16);
		queue_unit(CH_PERIOD, 1'b0, 1'b0, 8'd16);
		queue_unit(16'h0042, 1'b0, 1'b1, 8'd16);
		wait_drained();

		// No output space at all.
		write_reg(CFG_OUTPUT_CAPACITY, 10'd0);
		queue_unit(16'h0041, 1'b1, 1'b1, 8'd255);
		queue_unit(CH_NULL, 1'b1, 1'b0, 8'd255);
		queue_unit(16'h0041, 1'b0, 1'b1, 8'd255);
		wait_drained();

		// Largest capacity, then shrink it and continue without a new name.
		write_reg(CFG_OUTPUT_CAPACITY, 10'd1023);
		queue_unit(16'h0061, 1'b1, 1'b1, 8'd0);
		wait_drained();
		write_reg(CFG_OUTPUT_CAPACITY, 10'd5);
		queue_unit(16'h0042, 1'b0, 1'b1, 8'd4);

		// Random names across a spread of settings.
		run_phase(1'b1, 10'd255, 1'b1, 1'b1, 12);
		run_phase(1'b0, 10'd1023, 1'b1, 1'b1, 10);
		queue_long_name(258);
		run_phase(1'b1, 10'd0, 1'b1, 1'b0, 8);
		run_phase(1'b0, 10'($urandom_range(1, 12)), 1'b0, 1'b1, 12);
		run_phase(1'b1, 10'd1023, 1'b0, 1'b0, 12);
		run_phase(1'b1, 10'($urandom_range(3, 20)), 1'b1, 1'b1, 14);
		run_phase(1'b0, 10'd255, 1'b1, 1'b1, 12);
		run_phase(1'b1, 10'($urandom_range(0, 1023)), 1'b1, 1'b1, 12);
		run_phase(1'b0, 10'($urandom_range(1, 40)), 1'b1, 1'b1, 10);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && utf8_expected.size() == 0)
			$display("[cs0_name_to_utf8_encoder] OK");
		else
			$display("[cs0_name_to_utf8_encoder] ERROR");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20ms;
		$display("[cs0_name_to_utf8_encoder] ERROR");
		$finish;
	end

endmodule

// ----- cs0_name_to_utf8_encoder.f -----
src/nue_pkg.sv
src/nue_encode.sv
src/cs0_name_to_utf8_encoder.sv
tb/sv/tb_cs0_name_to_utf8_encoder.sv
